// ----- rtl/core/plc_pkg.sv -----
// ----------------------------------------------------------------------------
// plc_pkg
// Types and fixed constants shared by the palette colour blend pipeline.
// ----------------------------------------------------------------------------
package plc_pkg;

   localparam int COLOR_W    = 16;
   localparam int IDX_W      = 8;
   localparam int CNT_W      = 9;
   localparam int CHAN_W     = 5;
   localparam int NUM_CHAN   = 3;
   localparam int FLAG_POS   = 15;

   // Q12 weight: fraction bits, and one extra bit to hold 1.0 itself
   localparam int Q_SHIFT    = 12;
   localparam int T_W        = Q_SHIFT + 1;
   localparam logic [T_W-1:0] Q_ONE = T_W'(1 << Q_SHIFT);

   // divider: remainder stays below the count, quotient bits per stage
   localparam int REM_W      = CNT_W;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = Q_SHIFT / DIV_STEPS;

   localparam int PROD_W     = CHAN_W + T_W;

   typedef struct packed {
      logic [COLOR_W-1:0] color_a;
      logic [COLOR_W-1:0] color_b;
      logic [REM_W-1:0]   rem;
      logic [Q_SHIFT-1:0] quo;
      logic               sat;
   } plc_div_type;

   typedef struct packed {
      logic [NUM_CHAN-1:0][PROD_W-1:0] prod_a;
      logic [NUM_CHAN-1:0][PROD_W-1:0] prod_b;
      logic                            flag;
   } plc_prod_type;

endpackage

// ----- rtl/core/palette_color_lerp_top.sv -----
// ----------------------------------------------------------------------------
// palette_color_lerp_top
// Fade blend of two 5-5-5 palette colours plus flag bit, one word per cycle when the result side does not stall.
// ----------------------------------------------------------------------------
// Takes one request word (start colour, end colour, step index) every cycle
// while the result side does not stall, and returns one blended colour per
// request, in order. The weight t = index*4096/count is formed by a restoring
// divider spread over four register stages, three quotient bits each; a
// product stage and a sum stage then weight the red, green and blue fields.
// Every stage holds its own valid bit, so a stall on the result side only
// backs up as far as the first empty stage. An index at or above the count,
// or a count of zero, gives t = 4096 (end colour channels); the flag bit is
// always the OR of both flags. The count is clamped to MAX_STEPS.
// Write the count only while no request is in flight; there is no clearing
// pass after reset and the block accepts requests at once.
// ----------------------------------------------------------------------------
module palette_color_lerp_top import plc_pkg::*; #(
   parameter int MAX_STEPS = 256
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [COLOR_W-1:0] req_color_a,
   input  logic [COLOR_W-1:0] req_color_b,
   input  logic [IDX_W-1:0]   req_step_index,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COLOR_W-1:0] rsp_blended_color,
   // step count register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CNT_W-1:0]   csr_step_count
);

   logic [CNT_W-1:0] step_count_ff;
   logic [CNT_W-1:0] count;

   logic        div_valid [DIV_STAGES+1];
   plc_div_type div_data  [DIV_STAGES+1];
   logic        div_ready [DIV_STAGES+1];

   // the register takes a word in any cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= CNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         step_count_ff <= csr_step_count;
      end
   end

   // clamp the count; users must hold it still while words flow (not enforced); every stage reads it
   assign count = (int'(step_count_ff) > MAX_STEPS) ? CNT_W'(MAX_STEPS) : step_count_ff;

   // seed the divider: remainder starts at the index, quotient empty
   always_comb begin
      div_data[0].color_a = req_color_a;
      div_data[0].color_b = req_color_b;
      div_data[0].rem     = REM_W'(req_step_index);
      div_data[0].quo     = '0;
      div_data[0].sat     = (count == '0) || ({1'b0, req_step_index} >= count);
   end

   assign div_valid[0] = req_valid;
   assign req_stall    = !div_ready[0];

   // advance through the divider stages
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      plc_div_stage u_div_stage (
         .clock      (clock),
         .reset      (reset),
         .step_count (count),
         .in_valid   (div_valid[s]),
         .in_data    (div_data[s]),
         .in_ready   (div_ready[s]),
         .out_valid  (div_valid[s+1]),
         .out_data   (div_data[s+1]),
         .out_ready  (div_ready[s+1])
      );
   end

   // weight the channels and drive the result word
   plc_blend u_blend (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (div_valid[DIV_STAGES]),
      .in_data           (div_data[DIV_STAGES]),
      .in_ready          (div_ready[DIV_STAGES]),
      .rsp_valid         (rsp_valid),
      .rsp_blended_color (rsp_blended_color),
      .rsp_stall         (rsp_stall)
   );

endmodule

// ----- rtl/core/plc_div_stage.sv -----
// ----------------------------------------------------------------------------
// plc_div_stage
// One registered stage of the restoring divider that forms the blend weight.
// ----------------------------------------------------------------------------
module plc_div_stage import plc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] step_count,
   input  logic             in_valid,
   input  plc_div_type      in_data,
   output logic             in_ready,
   output logic             out_valid,
   output plc_div_type      out_data,
   input  logic             out_ready
);

   logic        valid_ff;
   plc_div_type data_ff;
   plc_div_type data_in;

   // shift the remainder, subtract the count where it fits
   always_comb begin
      logic [REM_W:0] rem_shift;
      data_in = in_data;
      for (int k = 0; k < DIV_STEPS; k++) begin
         rem_shift = {data_in.rem, 1'b0};
         if (rem_shift >= {1'b0, step_count}) begin
            data_in.rem = REM_W'(rem_shift - {1'b0, step_count});
            data_in.quo = {data_in.quo[Q_SHIFT-2:0], 1'b1};
         end else begin
            data_in.rem = rem_shift[REM_W-1:0];
            data_in.quo = {data_in.quo[Q_SHIFT-2:0], 1'b0};
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/core/plc_blend.sv -----
// ----------------------------------------------------------------------------
// plc_blend
// Weighting of the three channels: a product stage, then a sum stage that
// drives the result word.
// ----------------------------------------------------------------------------
module plc_blend import plc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  plc_div_type        in_data,
   output logic               in_ready,
   output logic               rsp_valid,
   output logic [COLOR_W-1:0] rsp_blended_color,
   input  logic               rsp_stall
);

   logic               prod_valid_ff;
   plc_prod_type       prod_ff;
   plc_prod_type       prod_in;
   logic               out_valid_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [COLOR_W-1:0] color_in;
   logic               out_ready;
   logic               sum_ready;

   always_comb begin
      logic [T_W-1:0] t;
      logic [T_W-1:0] w;
      t = in_data.sat ? Q_ONE : {1'b0, in_data.quo};
      w = Q_ONE - t;
      for (int c = 0; c < NUM_CHAN; c++) begin
         prod_in.prod_a[c] = PROD_W'(in_data.color_a[c*CHAN_W +: CHAN_W]) * PROD_W'(w);
         prod_in.prod_b[c] = PROD_W'(in_data.color_b[c*CHAN_W +: CHAN_W]) * PROD_W'(t);
      end
      prod_in.flag = in_data.color_a[FLAG_POS] | in_data.color_b[FLAG_POS];
   end

   always_comb begin
      logic [PROD_W:0] sum;
      color_in = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         sum = {1'b0, prod_ff.prod_a[c]} + {1'b0, prod_ff.prod_b[c]};
         color_in[c*CHAN_W +: CHAN_W] = sum[Q_SHIFT +: CHAN_W];
      end
      color_in[FLAG_POS] = prod_ff.flag;
   end

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign sum_ready = !prod_valid_ff || out_ready;
   assign in_ready  = sum_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (sum_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (out_ready) begin
            out_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sum_ready && in_valid) begin
         prod_ff <= prod_in;
      end
      if (out_ready && prod_valid_ff) begin
         color_ff <= color_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_blended_color = color_ff;

endmodule
